/* design/satellite_arc_tracker_unit_macros.svh */
// Assertion helpers used by the checker file of the arc tracker.
`ifndef SATELLITE_ARC_TRACKER_UNIT_MACROS_SVH
`define SATELLITE_ARC_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define SATU_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arc tracker check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define SATU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arc tracker check failed");

`endif

/* design/sat_arc_pkg.sv */
package sat_arc_pkg;

    // Fixed port widths.
    localparam int SLOT_W     = 7;
    localparam int EPOCH_W    = 40;
    localparam int ARC_OUT_W  = 16;
    localparam int CAUSE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PERIOD_W   = 32;

    // Reject causes.
    localparam logic [CAUSE_W-1:0] CAUSE_KEPT     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_MISSING  = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_SLIP     = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_UNSTABLE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DELETE_UNSTABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSTABLE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_SECOND    = 2'd2;

    // Per-slot status flags kept in the flag memory.
    typedef struct packed {
        logic seen;
        logic chg;
    } flag_t;

endpackage

/* design/satellite_arc_tracker_unit.sv */
// Sequence: a missing flag goes straight from the input transfer to DONE; a plain
// observation passes EVAL first, and the distance check adds DIFF, NEG if it borrowed, and CMP.
// One observation at a time: in_ready is high only in IDLE, reached once DONE has loaded the result.
// Reset: rst_n is asynchronous and active low; afterwards a clearing pass over all NUM_SATS
// slots wipes the per-slot flags while in_ready stays low (configuration still taken).
module satellite_arc_tracker_unit #(
    parameter int NUM_SATS   = 128,
    parameter int ARC_WIDTH  = 16,
    parameter int TIME_WIDTH = 40
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sat_arc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sat_arc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Observation input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sat_arc_pkg::SLOT_W-1:0]       sat_slot,
    input  logic                                 is_beidou,
    input  logic                                 first_present,
    input  logic                                 first_slip,
    input  logic                                 second_present,
    input  logic                                 second_slip,
    input  logic [sat_arc_pkg::EPOCH_W-1:0]      epoch_ms,
    // Result output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sat_arc_pkg::ARC_OUT_W-1:0]    arc_number,
    output logic                                 keep_sat,
    output logic [sat_arc_pkg::CAUSE_W-1:0]      reject_cause
);

    import sat_arc_pkg::*;

    // Index width of the slot tables and helper widths for explicit resizing.
    localparam int IDX_W    = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
    localparam int SLOT_EXT = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int EP_EXT   = (TIME_WIDTH > EPOCH_W) ? TIME_WIDTH : EPOCH_W;
    localparam int ARC_EXT  = (ARC_WIDTH > ARC_OUT_W) ? ARC_WIDTH : ARC_OUT_W;
    // The shared subtractor must hold both epochs and the 32-bit period.
    localparam int SUB_W    = (TIME_WIDTH > PERIOD_W) ? TIME_WIDTH : PERIOD_W;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_DIFF  = 7'b0001000,
        S_NEG   = 7'b0010000,
        S_CMP   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic                delete_unstable_reg;
    logic [PERIOD_W-1:0] unstable_period_reg;
    logic                watch_second_reg;

    // Clearing-pass counter.
    logic [IDX_W-1:0] clr_cnt_reg;

    // Captured observation.
    logic [IDX_W-1:0]      slot_idx_reg;
    logic                  slip_reg;
    logic [TIME_WIDTH-1:0] epoch_reg;

    // Result being built and the output register.
    logic [ARC_WIDTH-1:0]  res_arc_reg;
    logic [CAUSE_W-1:0]    res_cause_reg, res_cause_next;
    logic [SUB_W-1:0]      dist_reg;
    logic                  out_valid_reg;
    logic [ARC_WIDTH-1:0]  out_arc_reg;
    logic [CAUSE_W-1:0]    out_cause_reg;

    // Slot tables. The flag memory is cleared by the pass after reset; the arc and
    // change-epoch memories are only read where the flags say they were written.
    flag_t                 flag_mem   [NUM_SATS];
    logic [ARC_WIDTH-1:0]  arc_mem    [NUM_SATS];
    logic [TIME_WIDTH-1:0] epoch_mem  [NUM_SATS];
    flag_t                 flag_rd_reg;
    logic [ARC_WIDTH-1:0]  arc_rd_reg;
    logic [TIME_WIDTH-1:0] ce_rd_reg;

    // Input decode.
    logic                  in_xfer;
    logic                  use_second;
    logic                  flag_present;
    logic                  flag_slip;
    logic                  slot_in_range;
    logic [SLOT_EXT-1:0]   slot_wide;
    logic [IDX_W-1:0]      slot_idx;
    logic [EP_EXT-1:0]     epoch_wide;

    // Table update in the evaluation cycle.
    logic                  seen_old;
    logic                  chg_old;
    logic [ARC_WIDTH-1:0]  arc_old;
    logic [ARC_WIDTH-1:0]  arc_new;
    logic                  chg_new;

    // Shared subtractor.
    logic [SUB_W-1:0]      op_a, op_b;
    logic [SUB_W:0]        alu_diff;
    logic                  alu_borrow;

    // Memory write port.
    logic                  flag_we;
    logic [IDX_W-1:0]      flag_waddr;
    flag_t                 flag_wdata;
    logic                  out_load;

    logic [ARC_EXT-1:0]    arc_out_wide;

    // ------------------------------------------------------------------
    // Configuration: always ready, writes to an unknown index are dropped.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delete_unstable_reg <= 1'b0;
            unstable_period_reg <= '0;
            watch_second_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DELETE_UNSTABLE: delete_unstable_reg <= cfg_data[0];
                CFG_UNSTABLE_PERIOD: unstable_period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_WATCH_SECOND:    watch_second_reg    <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode. BeiDou always watches the second flag; other systems
    // follow the configuration. A slot beyond the table is treated as a
    // missing flag and never touches the table.
    // ------------------------------------------------------------------
    assign in_ready      = (state_reg == S_IDLE);
    assign in_xfer       = in_valid && in_ready;
    assign use_second    = is_beidou || watch_second_reg;
    assign flag_present  = use_second ? second_present : first_present;
    assign flag_slip     = use_second ? second_slip : first_slip;
    assign slot_in_range = (32'(sat_slot) < 32'(NUM_SATS));
    assign slot_wide     = SLOT_EXT'(sat_slot);
    assign slot_idx      = slot_wide[IDX_W-1:0];
    assign epoch_wide    = EP_EXT'(epoch_ms);

    // ------------------------------------------------------------------
    // Evaluation: a slot seen for the first time starts at arc 0 with no
    // change epoch. A slip bumps the arc, saturating at all ones.
    // ------------------------------------------------------------------
    assign seen_old = flag_rd_reg.seen;
    assign chg_old  = flag_rd_reg.seen && flag_rd_reg.chg;
    assign arc_old  = seen_old ? arc_rd_reg : '0;
    assign arc_new  = (slip_reg && (arc_old != {ARC_WIDTH{1'b1}})) ?
                      arc_old + ARC_WIDTH'(1) : arc_old;
    assign chg_new  = chg_old || slip_reg;

    // ------------------------------------------------------------------
    // Shared subtractor. The distance check takes up to three passes:
    // epoch minus change epoch, the reverse if that borrowed, and finally
    // period minus distance, where no borrow means inside the period.
    // ------------------------------------------------------------------
    always_comb
    begin
        op_a = SUB_W'(epoch_reg);
        op_b = SUB_W'(ce_rd_reg);
        case (state_reg)
            S_DIFF:
            begin
                op_a = SUB_W'(epoch_reg);
                op_b = SUB_W'(ce_rd_reg);
            end
            S_NEG:
            begin
                op_a = SUB_W'(ce_rd_reg);
                op_b = SUB_W'(epoch_reg);
            end
            S_CMP:
            begin
                op_a = SUB_W'(unstable_period_reg);
                op_b = dist_reg;
            end
            default:
            begin
                op_a = SUB_W'(epoch_reg);
                op_b = SUB_W'(ce_rd_reg);
            end
        endcase
    end

    assign alu_diff   = {1'b0, op_a} - {1'b0, op_b};
    assign alu_borrow = alu_diff[SUB_W];

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        res_cause_next = res_cause_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(NUM_SATS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (flag_present && slot_in_range)
                    begin
                        state_next = S_EVAL;
                    end
                    else
                    begin
                        state_next     = S_DONE;
                        res_cause_next = CAUSE_MISSING;
                    end
                end
            end
            S_EVAL:
            begin
                if (slip_reg && delete_unstable_reg)
                begin
                    state_next     = S_DONE;
                    res_cause_next = CAUSE_SLIP;
                end
                else if (delete_unstable_reg && chg_new)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next     = S_DONE;
                    res_cause_next = CAUSE_KEPT;
                end
            end
            S_DIFF:
            begin
                state_next = alu_borrow ? S_NEG : S_CMP;
            end
            S_NEG:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next     = S_DONE;
                res_cause_next = alu_borrow ? CAUSE_KEPT : CAUSE_UNSTABLE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset; control decides when they matter.
    always_ff @(posedge clk)
    begin
        res_cause_reg <= res_cause_next;
        if (in_xfer)
        begin
            slot_idx_reg <= slot_idx;
            slip_reg     <= flag_slip;
            epoch_reg    <= epoch_wide[TIME_WIDTH-1:0];
            res_arc_reg  <= '0;
        end
        if (state_reg == S_EVAL)
        begin
            res_arc_reg <= arc_new;
        end
        if ((state_reg == S_DIFF) || (state_reg == S_NEG))
        begin
            dist_reg <= alu_diff[SUB_W-1:0];
        end
        if (out_load)
        begin
            out_arc_reg   <= res_arc_reg;
            out_cause_reg <= res_cause_next;
        end
    end

    // ------------------------------------------------------------------
    // Slot tables: one write and one registered read per cycle. The read
    // is launched with the input transfer; the write back happens in the
    // evaluation cycle, well before the next observation can read.
    // ------------------------------------------------------------------
    assign flag_we    = (state_reg == S_CLEAR) || (state_reg == S_EVAL);
    assign flag_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : slot_idx_reg;
    always_comb
    begin
        flag_wdata.seen = (state_reg == S_EVAL);
        flag_wdata.chg  = (state_reg == S_EVAL) && chg_new;
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        if (state_reg == S_EVAL)
        begin
            arc_mem[slot_idx_reg] <= arc_new;
            if (slip_reg)
            begin
                epoch_mem[slot_idx_reg] <= epoch_reg;
            end
        end
        if (in_xfer)
        begin
            flag_rd_reg <= flag_mem[slot_idx];
            arc_rd_reg  <= arc_mem[slot_idx];
            ce_rd_reg   <= epoch_mem[slot_idx];
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds the finished result until its transfer.
    // ------------------------------------------------------------------
    assign arc_out_wide = ARC_EXT'(out_arc_reg);
    assign out_valid    = out_valid_reg;
    assign arc_number   = arc_out_wide[ARC_OUT_W-1:0];
    assign reject_cause = out_cause_reg;
    assign keep_sat     = (out_cause_reg == CAUSE_KEPT);

endmodule

/* design/sat_arc_checker.sv */
`include "satellite_arc_tracker_unit_macros.svh"

module sat_arc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [sat_arc_pkg::ARC_OUT_W-1:0]  arc_number,
    input logic                               keep_sat,
    input logic [sat_arc_pkg::CAUSE_W-1:0]    reject_cause
);

    import sat_arc_pkg::*;

    // A waiting result must not vanish before its transfer.
    `SATU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // The keep flag and the cause code must tell the same story.
    `SATU_ASSERT_NOW(a_keep_matches_cause, out_valid, keep_sat == (reject_cause == CAUSE_KEPT))

    // A missing flag reports arc zero.
    `SATU_ASSERT_NOW(a_missing_arc_zero, out_valid && (reject_cause == CAUSE_MISSING), arc_number == '0)

    // One observation at a time: the block is busy right after an input transfer.
    `SATU_ASSERT_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready)

endmodule

bind satellite_arc_tracker_unit sat_arc_checker u_sat_arc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .arc_number   (arc_number),
    .keep_sat     (keep_sat),
    .reject_cause (reject_cause)
);

/* tb/sv/arc_track_tb_pkg.sv */
`timescale 1ns / 1ps

package arc_track_tb_pkg;

    import sat_arc_pkg::*;

    localparam int TRACK_SLOTS = 1 << SLOT_W;
    localparam logic [ARC_OUT_W-1:0] ARC_CEILING = '1;

    // One observation as it crosses the input channel.
    typedef struct packed {
        logic [SLOT_W-1:0]  sat_slot;
        logic               is_beidou;
        logic               first_present;
        logic               first_slip;
        logic               second_present;
        logic               second_slip;
        logic [EPOCH_W-1:0] epoch_ms;
    } sat_obs_t;

    // One verdict as it crosses the result channel.
    typedef struct packed {
        logic [ARC_OUT_W-1:0] arc_number;
        logic                 keep_sat;
        logic [CAUSE_W-1:0]   reject_cause;
    } arc_verdict_t;

    class arc_verdict_board;

        bit                  delete_unstable;
        logic [PERIOD_W-1:0] unstable_period;
        bit                  watch_second;

        bit                   slot_seen[TRACK_SLOTS];
        logic [ARC_OUT_W-1:0] slot_arc[TRACK_SLOTS];
        bit                   slot_has_change[TRACK_SLOTS];
        logic [EPOCH_W-1:0]   slot_change_epoch[TRACK_SLOTS];

        arc_verdict_t awaited_verdicts[$];
        int unsigned  mismatches;

        function new();
            delete_unstable = 1'b0;
            unstable_period = '0;
            watch_second    = 1'b0;
            mismatches      = 0;
            for (int s = 0; s < TRACK_SLOTS; s++) begin
                slot_seen[s]         = 1'b0;
                slot_arc[s]          = '0;
                slot_has_change[s]   = 1'b0;
                slot_change_epoch[s] = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DELETE_UNSTABLE: delete_unstable = data[0];
                CFG_UNSTABLE_PERIOD: unstable_period = data[PERIOD_W-1:0];
                CFG_WATCH_SECOND:    watch_second    = data[0];
                default: ;
            endcase
        endfunction

        // Works out the verdict for an accepted observation and updates the arc table.
        function void note_observation(sat_obs_t o);
            bit                 use_second;
            bit                 present;
            bit                 slip;
            int unsigned        s;
            logic [EPOCH_W-1:0] ce;
            logic [EPOCH_W-1:0] span_ms;
            arc_verdict_t       v;
            use_second = o.is_beidou || watch_second;
            present    = use_second ? o.second_present : o.first_present;
            slip       = use_second ? o.second_slip : o.first_slip;
            v.arc_number   = '0;
            v.keep_sat     = 1'b0;
            v.reject_cause = CAUSE_MISSING;
            if (present) begin
                s = o.sat_slot;
                if (!slot_seen[s]) begin
                    slot_seen[s]       = 1'b1;
                    slot_arc[s]        = '0;
                    slot_has_change[s] = 1'b0;
                end
                v.reject_cause = CAUSE_KEPT;
                if (slip) begin
                    if (slot_arc[s] != ARC_CEILING)
                        slot_arc[s] = slot_arc[s] + 1'b1;
                    slot_change_epoch[s] = o.epoch_ms;
                    slot_has_change[s]   = 1'b1;
                    if (delete_unstable)
                        v.reject_cause = CAUSE_SLIP;
                end
                if (v.reject_cause == CAUSE_KEPT && delete_unstable && slot_has_change[s]) begin
                    ce      = slot_change_epoch[s];
                    span_ms = (o.epoch_ms >= ce) ? o.epoch_ms - ce : ce - o.epoch_ms;
                    if (span_ms <= EPOCH_W'(unstable_period))
                        v.reject_cause = CAUSE_UNSTABLE;
                end
                v.arc_number = slot_arc[s];
                v.keep_sat   = (v.reject_cause == CAUSE_KEPT);
            end
            awaited_verdicts.push_back(v);
        endfunction

        function void report(string what, arc_verdict_t want, arc_verdict_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected arc %0d keep %0b cause %0d, got arc %0d keep %0b cause %0d",
                         $time, what, want.arc_number, want.keep_sat, want.reject_cause,
                         got.arc_number, got.keep_sat, got.reject_cause);
        endfunction

        // Compares one delivered verdict with the oldest one still awaited.
        function void check_result(arc_verdict_t got);
            arc_verdict_t want;
            if (awaited_verdicts.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = awaited_verdicts.pop_front();
            if (got.arc_number !== want.arc_number || got.keep_sat !== want.keep_sat ||
                got.reject_cause !== want.reject_cause)
                report("result mismatch", want, got);
        endfunction

        function int pending();
            return awaited_verdicts.size();
        endfunction

    endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import sat_arc_pkg::*;
    import arc_track_tb_pkg::*;

    // Index 3 has no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic [EPOCH_W-1:0]   EPOCH_TOP        = '1;
    localparam int                   RANDOM_PHASES    = 6;
    localparam int                   ITEMS_PER_PHASE  = 275;
    localparam int                   LONG_HOLD_CYCLES = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [SLOT_W-1:0]     sat_slot;
    logic                  is_beidou;
    logic                  first_present;
    logic                  first_slip;
    logic                  second_present;
    logic                  second_slip;
    logic [EPOCH_W-1:0]    epoch_ms;
    logic                  out_valid;
    logic                  out_ready;
    logic [ARC_OUT_W-1:0]  arc_number;
    logic                  keep_sat;
    logic [CAUSE_W-1:0]    reject_cause;

    arc_verdict_board board;

    // Idling is switched off for the closing phase.
    bit no_gaps;
    // Set by the main sequence to ask the result side for one long hold-off.
    bit hold_pending;

    // Unstable period currently programmed, used to aim epochs at its edges.
    logic [PERIOD_W-1:0] cur_period;
    // Per slot, the epoch of the last slip offered, the anchor for nearby epochs.
    logic [EPOCH_W-1:0]  slot_anchor[TRACK_SLOTS];

    satellite_arc_tracker_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sat_slot       (sat_slot),
        .is_beidou      (is_beidou),
        .first_present  (first_present),
        .first_slip     (first_slip),
        .second_present (second_present),
        .second_slip    (second_slip),
        .epoch_ms       (epoch_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .arc_number     (arc_number),
        .keep_sat       (keep_sat),
        .reject_cause   (reject_cause)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Every transfer on the result channel is checked against the oldest
    // prediction. Sampling right after the edge sees the values that were
    // present at the edge, since the block and the driver update by NBA.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result('{arc_number, keep_sat, reject_cause});
    end

    // Result side back-pressure. Each pass drives out_ready once and then lets
    // at least one edge go by, so the signal never sees two updates in a step.
    // Ready stretches are long enough that there are runs with no stall at all.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_pending) begin
                // The long hold-off: the sender keeps offering observations,
                // so the pipeline fills and in_ready has to drop.
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Guard against a hung handshake. The slowest legal run is about 1700
    // observations, each through the full distance check, plus idle bursts
    // on either side and the long hold-off; this limit leaves several times
    // that.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic sat_obs_t make_obs(int slot, bit bd, bit p1, bit s1, bit p2, bit s2,
                                          logic [EPOCH_W-1:0] ep);
        sat_obs_t o;
        o.sat_slot       = SLOT_W'(slot);
        o.is_beidou      = bd;
        o.first_present  = p1;
        o.first_slip     = s1;
        o.second_present = p2;
        o.second_slip    = s2;
        o.epoch_ms       = ep;
        return o;
    endfunction

    // Random observations concentrate on a few slots so arcs grow and the
    // unstable window is exercised; epochs mostly land around the last slip,
    // often exactly on or just past the period boundary in either direction.
    // Missing flags and fully random epochs make up the noise.
    function automatic sat_obs_t random_obs();
        sat_obs_t           o;
        logic [EPOCH_W-1:0] a;
        logic [EPOCH_W-1:0] p;
        logic [EPOCH_W-1:0] d;
        o.sat_slot = ($urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, 7))
                                                : SLOT_W'($urandom_range(0, TRACK_SLOTS - 1));
        o.is_beidou      = ($urandom_range(0, 9) < 3);
        o.first_present  = ($urandom_range(0, 9) != 0);
        o.first_slip     = ($urandom_range(0, 3) == 0);
        o.second_present = ($urandom_range(0, 9) != 0);
        o.second_slip    = ($urandom_range(0, 3) == 0);
        a = slot_anchor[o.sat_slot];
        p = EPOCH_W'(cur_period);
        case ($urandom_range(0, 9))
            0: o.epoch_ms = {8'($urandom_range(0, 255)), 32'($urandom)};
            1: o.epoch_ms = a + p;
            2: o.epoch_ms = a - p;
            3: o.epoch_ms = a + p + 1'b1;
            4: o.epoch_ms = a - p - 1'b1;
            default:
            begin
                if (cur_period < 100000)
                    d = EPOCH_W'($urandom_range(0, 2 * cur_period + 2));
                else
                    d = EPOCH_W'($urandom);
                o.epoch_ms = $urandom_range(0, 1) ? a + d : a - d;
            end
        endcase
        if (o.first_slip || o.second_slip)
            slot_anchor[o.sat_slot] = o.epoch_ms;
        return o;
    endfunction

    // Offers one observation and holds it until the transfer happens. Valid is
    // left high so a following observation can be offered without a gap.
    task automatic send_obs(sat_obs_t o);
        in_valid       <= 1'b1;
        sat_slot       <= o.sat_slot;
        is_beidou      <= o.is_beidou;
        first_present  <= o.first_present;
        first_slip     <= o.first_slip;
        second_present <= o.second_present;
        second_slip    <= o.second_slip;
        epoch_ms       <= o.epoch_ms;
        do @(posedge clk); while (!in_ready);
        board.note_observation(o);
    endtask

    // A random burst of idle cycles on the input side.
    task automatic input_gap();
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    // Waits until every predicted verdict has come back and the pipeline has
    // had time to settle after its deepest path, the full distance check.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
    endtask

    // Programs all three registers back to back while the block is idle. The
    // single-bit registers get random upper bits, which must be ignored.
    task automatic apply_setting(bit del, logic [PERIOD_W-1:0] period, bit watch,
                                 bit poke_unused);
        drain();
        cfg_write(CFG_DELETE_UNSTABLE, {$urandom} & ~32'd1 | 32'(del));
        cfg_write(CFG_UNSTABLE_PERIOD, period);
        cfg_write(CFG_WATCH_SECOND, {$urandom} & ~32'd1 | 32'(watch));
        if (poke_unused)
            cfg_write(CFG_UNUSED_INDEX, $urandom);
        cfg_valid  <= 1'b0;
        cur_period  = period;
        @(posedge clk);
    endtask

    initial
    begin
        bit                  del;
        bit                  watch;
        logic [PERIOD_W-1:0] period;

        board        = new();
        no_gaps      = 1'b0;
        hold_pending = 1'b0;
        cur_period   = '0;
        for (int s = 0; s < TRACK_SLOTS; s++)
            slot_anchor[s] = {8'($urandom_range(0, 255)), 32'($urandom)};

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        sat_slot       <= '0;
        is_beidou      <= 1'b0;
        first_present  <= 1'b0;
        first_slip     <= 1'b0;
        second_present <= 1'b0;
        second_slip    <= 1'b0;
        epoch_ms       <= '0;
        out_ready      <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Deleting on, zero-length unstable window, first flag watched. The
        // clearing pass after reset still accepts these writes.
        apply_setting(1'b1, '0, 1'b0, 1'b1);
        send_obs(make_obs(0, 0, 0, 1, 1, 1, EPOCH_TOP));   // first flag missing
        send_obs(make_obs(127, 0, 1, 0, 0, 0, '0));        // first sighting
        send_obs(make_obs(127, 0, 1, 1, 0, 0, EPOCH_TOP)); // slip, reported as slip
        send_obs(make_obs(127, 0, 1, 0, 0, 0, EPOCH_TOP)); // distance zero, unstable
        send_obs(make_obs(127, 0, 1, 0, 0, 0, EPOCH_TOP - 1'b1));
        send_obs(make_obs(127, 0, 1, 0, 1, 1, '0));        // far earlier epoch, kept
        send_obs(make_obs(1, 1, 1, 1, 0, 0, 40'd500));     // BeiDou, second flag missing
        send_obs(make_obs(1, 1, 0, 0, 1, 1, 40'd500));     // BeiDou slip on a new slot
        send_obs(make_obs(2, 0, 0, 0, 1, 0, 40'd9));       // second flag ignored

        // Widest window, second flag watched for every constellation.
        apply_setting(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_obs(make_obs(3, 0, 1, 1, 0, 0, 40'h100));
        send_obs(make_obs(3, 0, 1, 1, 1, 0, 40'h100));
        send_obs(make_obs(3, 0, 0, 0, 1, 1, 40'hFF_FFFF_0000));
        send_obs(make_obs(3, 0, 1, 1, 1, 0, 40'hFE_FFFF_0001)); // exactly on the edge
        send_obs(make_obs(3, 0, 1, 1, 1, 0, 40'hFE_FFFF_0000)); // one past the edge
        send_obs(make_obs(127, 0, 0, 0, 1, 0, EPOCH_TOP - 40'd5));
        send_obs(make_obs(1, 1, 1, 0, 1, 0, 40'd400));

        // Deleting off: a present flag always keeps the satellite.
        apply_setting(1'b0, 32'd5, 1'b0, 1'b0);
        send_obs(make_obs(127, 0, 1, 1, 1, 0, 40'd7));
        send_obs(make_obs(127, 0, 1, 0, 0, 0, 40'd7));
        send_obs(make_obs(9, 0, 0, 1, 1, 1, 40'd7));
        send_obs(make_obs(1, 1, 0, 0, 1, 0, 40'd7));

        // Random phases over a range of settings, extremes included. The long
        // result-side hold-off is requested in the second phase, and the last
        // phase runs with no idling at all.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: begin del = 1'b1; period = '0;                          end
                1: begin del = 1'b1; period = 32'd1;                       end
                2: begin del = 1'b1; period = 32'($urandom_range(2, 2000)); end
                3: begin del = 1'b1; period = 32'hFFFF_FFFF;               end
                4: begin del = 1'b0; period = $urandom;                    end
                default: begin del = 1'b1; period = 32'($urandom_range(0, 500)); end
            endcase
            watch = ph[0];
            apply_setting(del, period, watch, 1'b0);
            if (ph == 1)
                hold_pending = 1'b1;
            if (ph == RANDOM_PHASES - 1)
                no_gaps = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                input_gap();
                send_obs(random_obs());
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
